// File: rtl/core/polar_cartesian_converter_top_macros.svh
// Assertion helpers used by the converter top module.
`ifndef POLAR_CARTESIAN_CONVERTER_TOP_MACROS_SVH
`define POLAR_CARTESIAN_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, checked while reset is released.
`define CPC_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while reset is released.
`define CPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/cpc_pkg.sv
package cpc_pkg;

	// Configuration of the rotation chain and the Cartesian output range.
	localparam int ITERATIONS  = 16;
	localparam int COORD_WIDTH = 16;
	localparam int MAX_STEPS   = 24;
	localparam int NSTEPS      = (ITERATIONS > MAX_STEPS) ? MAX_STEPS : ITERATIONS;
	localparam int IDX_W       = $clog2(MAX_STEPS);

	// Internal datapath widths: coordinates carry 16 extra fraction bits.
	localparam int DW = 36;
	localparam int ZW = 33;

	// Inverse CORDIC gain in Q30.
	localparam logic [29:0] GAIN = 30'd652032874;

	// Saturation bounds for the Cartesian results, one bit wider than DW.
	localparam logic signed [DW:0] CLIP_HI =
		(DW+1)'((65'sd1 <<< (COORD_WIDTH - 1)) - 65'sd1);
	localparam logic signed [DW:0] CLIP_LO = -CLIP_HI - (DW+1)'(1);

	// One item moving along the rotation chain.
	typedef struct packed {
		logic                 op;
		logic                 zero;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
	} stage_t;

	// One finished result.
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] radius;
		logic [15:0] angle;
		logic        sat;
	} result_t;

	// Arctangent of 2^-i as a 32-bit binary angle.
	function automatic logic [31:0] atan_val(input logic [IDX_W-1:0] idx);
		logic [31:0] v;
		unique case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2F9;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/polar_cartesian_converter_top.sv
// Polar/Cartesian converter built on an unrolled CORDIC chain.
// Command channel: cmd_valid/cmd_ready carry op, radius_in, angle_in, x_in and
// y_in. With op 0 the polar pair is rotated into x_out, y_out and saturated;
// with op 1 the Cartesian pair is vectored into radius_out and angle_out.
// Fields that do not belong to the operation read as zero.
// Result channel: res_valid/res_ready carry one result per command transaction.
// The pipeline has one setup stage, one cell per micro-rotation, and two output
// stages for the gain multiply of the radius. A new transaction is taken every
// cycle while the skid register is empty; the rate is set by the chain of
// rotation cells, which all advance together.
// When the receiver stalls, the result at the end of the chain drops into a
// one-entry skid register and cmd_ready falls in the next cycle; the chain
// then holds until the skid register is read.
// Reset (arst_n low) clears the stage valid bits and the skid valid bit, so
// no result is presented after reset until a new transaction is accepted.
`include "polar_cartesian_converter_top_macros.svh"

module polar_cartesian_converter_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  logic                op,
	input  logic [14:0]         radius_in,
	input  logic signed [15:0]  angle_in,
	input  logic signed [15:0]  x_in,
	input  logic signed [15:0]  y_in,
	output logic                res_valid,
	input  logic                res_ready,
	output logic signed [15:0]  x_out,
	output logic signed [15:0]  y_out,
	output logic [15:0]         radius_out,
	output logic signed [15:0]  angle_out,
	output logic                saturated
);

	localparam int L = cpc_pkg::NSTEPS + 3;

	logic             en;
	logic [L-1:0]     vld_q;
	logic             skid_vld_q;
	cpc_pkg::result_t skid_q;
	cpc_pkg::result_t last;
	cpc_pkg::result_t sel;
	cpc_pkg::stage_t  st [0:cpc_pkg::NSTEPS];

	// The whole chain moves while the skid register is empty.
	assign en        = ~skid_vld_q;
	assign cmd_ready = en;

	cpc_prep u_prep (
		.clk       (clk),
		.en        (en),
		.op        (op),
		.radius_in (radius_in),
		.angle_in  (angle_in),
		.x_in      (x_in),
		.y_in      (y_in),
		.q_s0      (st[0])
	);

	// One rotation cell per iteration.
	for (genvar k = 0; k < cpc_pkg::NSTEPS; k++) begin : g_cell
		cpc_cell u_cell (
			.clk (clk),
			.en  (en),
			.idx (cpc_pkg::IDX_W'(k)),
			.d   (st[k]),
			.q   (st[k+1])
		);
	end

	cpc_post u_post (
		.clk    (clk),
		.en     (en),
		.d      (st[cpc_pkg::NSTEPS]),
		.res_s2 (last)
	);

	// Valid bits follow the data through the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], cmd_valid};
		end
	end

	// Skid register catches the last result when the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (res_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (vld_q[L-1] && !res_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_q <= last;
		end
	end

	// Result selection: the skid entry is older and goes first.
	assign sel        = skid_vld_q ? skid_q : last;
	assign res_valid  = skid_vld_q | vld_q[L-1];
	assign x_out      = sel.x;
	assign y_out      = sel.y;
	assign radius_out = sel.radius;
	assign angle_out  = sel.angle;
	assign saturated  = sel.sat;

	`CPC_ASSERT_NXT(a_skid_hold, clk, arst_n, skid_vld_q && !res_ready, skid_vld_q, "skid entry lost while stalled")
	`CPC_ASSERT(a_skid_src, clk, arst_n, $rose(skid_vld_q), $past(vld_q[L-1]), "skid loaded without a finished result")
	`CPC_ASSERT(a_sat_polar, clk, arst_n, res_valid && saturated, radius_out == 16'h0000 && angle_out == 16'sh0000, "saturation flagged on a polar result")
	`CPC_ASSERT_NXT(a_stall_chain, clk, arst_n, skid_vld_q && !res_ready, $stable(vld_q), "chain moved while skid register full")

endmodule

// File: rtl/core/cpc_prep.sv
module cpc_prep (
	input  logic                 clk,
	input  logic                 en,
	input  logic                 op,
	input  logic [14:0]          radius_in,
	input  logic signed [15:0]   angle_in,
	input  logic signed [15:0]   x_in,
	input  logic signed [15:0]   y_in,
	output cpc_pkg::stage_t      q_s0
);

	cpc_pkg::stage_t nxt;

	// Set up the start vector and angle for either direction.
	always_comb begin
		logic [44:0]                   prod;
		logic signed [cpc_pkg::DW-1:0] r0;
		logic signed [cpc_pkg::DW-1:0] xe;
		logic signed [cpc_pkg::DW-1:0] ye;
		logic                          flip;
		logic [15:0]                   ang;
		prod = 45'(radius_in) * 45'(cpc_pkg::GAIN);
		r0   = cpc_pkg::DW'(prod[44:14]);
		flip = angle_in[15] ^ angle_in[14];
		ang  = {angle_in[15] ^ flip, angle_in[14:0]};
		xe   = {{(cpc_pkg::DW-32){x_in[15]}}, x_in, 16'h0000};
		ye   = {{(cpc_pkg::DW-32){y_in[15]}}, y_in, 16'h0000};
		nxt.op   = op;
		nxt.zero = (x_in == 16'sd0) && (y_in == 16'sd0);
		if (!op) begin
			// Fold the left half plane by a half turn.
			nxt.x = flip ? -r0 : r0;
			nxt.y = '0;
			nxt.z = {{(cpc_pkg::ZW-32){ang[15]}}, ang, 16'h0000};
		end else begin
			nxt.x = x_in[15] ? -xe : xe;
			nxt.y = x_in[15] ? -ye : ye;
			nxt.z = x_in[15] ? cpc_pkg::ZW'(32'h8000_0000) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s0 <= nxt;
		end
	end

endmodule

// File: rtl/core/cpc_cell.sv
module cpc_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [cpc_pkg::IDX_W-1:0]     idx,
	input  cpc_pkg::stage_t               d,
	output cpc_pkg::stage_t               q
);

	cpc_pkg::stage_t nxt;

	// One micro-rotation; the direction follows z when rotating and y when vectoring.
	always_comb begin
		logic signed [cpc_pkg::DW-1:0] xv;
		logic signed [cpc_pkg::DW-1:0] yv;
		logic signed [cpc_pkg::ZW-1:0] zv;
		logic signed [cpc_pkg::DW-1:0] xs;
		logic signed [cpc_pkg::DW-1:0] ys;
		logic signed [cpc_pkg::ZW-1:0] at;
		logic                          dir;
		xv  = d.x;
		yv  = d.y;
		zv  = d.z;
		xs  = xv >>> idx;
		ys  = yv >>> idx;
		at  = cpc_pkg::ZW'(cpc_pkg::atan_val(idx));
		dir = d.op ? yv[cpc_pkg::DW-1] : ~zv[cpc_pkg::ZW-1];
		nxt = d;
		if (dir) begin
			nxt.x = xv - ys;
			nxt.y = yv + xs;
			nxt.z = zv - at;
		end else begin
			nxt.x = xv + ys;
			nxt.y = yv - xs;
			nxt.z = zv + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// File: rtl/core/cpc_post.sv
module cpc_post (
	input  logic                 clk,
	input  logic                 en,
	input  cpc_pkg::stage_t      d,
	output cpc_pkg::result_t     res_s2
);

	logic        op_s1;
	logic        zero_s1;
	logic [15:0] x_s1;
	logic [15:0] y_s1;
	logic        sat_s1;
	logic [15:0] angle_s1;
	logic [46:0] pl_s1;
	logic [45:0] ph_s1;

	logic [15:0] xc;
	logic [15:0] yc;
	logic        satc;
	logic [15:0] angc;

	// Round and clip the Cartesian pair, round the angle.
	always_comb begin
		logic signed [cpc_pkg::DW-1:0] xv;
		logic signed [cpc_pkg::DW-1:0] yv;
		logic signed [cpc_pkg::DW:0]   xr;
		logic signed [cpc_pkg::DW:0]   yr;
		logic [31:0]                   zs;
		xv   = d.x;
		yv   = d.y;
		xr   = ((cpc_pkg::DW+1)'(xv) + (cpc_pkg::DW+1)'(32'sd32768)) >>> 16;
		yr   = ((cpc_pkg::DW+1)'(yv) + (cpc_pkg::DW+1)'(32'sd32768)) >>> 16;
		satc = 1'b0;
		if (xr > cpc_pkg::CLIP_HI) begin
			xr   = cpc_pkg::CLIP_HI;
			satc = 1'b1;
		end else if (xr < cpc_pkg::CLIP_LO) begin
			xr   = cpc_pkg::CLIP_LO;
			satc = 1'b1;
		end
		if (yr > cpc_pkg::CLIP_HI) begin
			yr   = cpc_pkg::CLIP_HI;
			satc = 1'b1;
		end else if (yr < cpc_pkg::CLIP_LO) begin
			yr   = cpc_pkg::CLIP_LO;
			satc = 1'b1;
		end
		xc   = xr[15:0];
		yc   = yr[15:0];
		zs   = d.z[31:0] + 32'h0000_8000;
		angc = zs[31:16];
	end

	// First stage: split the gain multiply into two partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= d.op;
			zero_s1  <= d.zero;
			x_s1     <= xc;
			y_s1     <= yc;
			sat_s1   <= satc;
			angle_s1 <= angc;
			pl_s1    <= 47'(d.x[16:0]) * 47'(cpc_pkg::GAIN);
			ph_s1    <= 46'(d.x[32:17]) * 46'(cpc_pkg::GAIN);
		end
	end

	cpc_pkg::result_t nxt;

	// Second stage: sum the partial products, round the radius and select fields.
	always_comb begin
		logic [63:0] sum;
		logic [17:0] rad;
		sum = (64'(ph_s1) << 17) + 64'(pl_s1) + (64'd1 << 45);
		rad = sum[63:46];
		nxt = '0;
		if (!op_s1) begin
			nxt.x   = x_s1;
			nxt.y   = y_s1;
			nxt.sat = sat_s1;
		end else if (!zero_s1) begin
			nxt.radius = (rad > 18'd65535) ? 16'hFFFF : rad[15:0];
			nxt.angle  = angle_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= nxt;
		end
	end

endmodule
